### design/enrichment_score_two_pass_macros.svh
// ---------------------------------------------------------------------------
// enrichment score assertion macros
// shared concurrent assertion forms, clocked on clk, quiet in reset
// ---------------------------------------------------------------------------
`ifndef ENRICHMENT_SCORE_TWO_PASS_MACROS_SVH
`define ENRICHMENT_SCORE_TWO_PASS_MACROS_SVH

// condition holds at every edge
`define ESP_ASSERT_ALWAYS(lbl, cond, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define ESP_ASSERT_NEXT(lbl, pre, post, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

### design/esp_pkg.sv
// ---------------------------------------------------------------------------
// esp_pkg
// types and constants shared by the enrichment score block
// ---------------------------------------------------------------------------
package esp_pkg;

	localparam int DEF_MAX_LEN = 65536;

	localparam logic [0:0] CFG_WEIGHT_EXPONENT = 1'd0;
	localparam logic [0:0] CFG_SCORE_MODE      = 1'd1;

	localparam logic [1:0] MODE_EXTREME = 2'd0;
	localparam logic [1:0] MODE_MAX     = 2'd1;
	localparam logic [1:0] MODE_MIN     = 2'd2;

	localparam logic [2:0]  EXP_RESET  = 3'd1;
	localparam logic [2:0]  EXP_MAX    = 3'd4;
	localparam logic [63:0] ONE_Q16    = 64'd65536;
	localparam logic [30:0] Q30_CAP    = 31'h7FFF_FFFF;
	localparam logic [4:0]  DIV_STEPS  = 5'd30;

	typedef struct packed {
		logic        func;
		logic signed [31:0] stat;
		logic        in_set;
		logic        last;
	} item_t;

	typedef struct packed {
		logic [16:0]        position;
		logic signed [31:0] running_score;
		logic               hit;
		logic signed [31:0] enrichment;
		logic               enrichment_valid;
	} result_t;

	typedef struct packed {
		logic load;
		logic mul_lo;
		logic mul_hi;
		logic mul_acc;
		logic div_init;
		logic div_step;
		logic update;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic func;
		logic mul_left;
		logic need_div;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

### design/esp_dp.sv
// ---------------------------------------------------------------------------
// esp_dp
// datapath: weight multiplier, shared q30 divider, totals, scan and output
// ---------------------------------------------------------------------------
module esp_dp #(
	parameter int MAX_LEN = esp_pkg::DEF_MAX_LEN
) (
	input  logic             clk,
	input  logic             arst_n,
	input  esp_pkg::item_t   item,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [2:0]       cfg_data,
	input  esp_pkg::cmd_t    cmd,
	output esp_pkg::sts_t    sts,
	output logic             result_valid,
	input  logic             result_ready,
	output esp_pkg::result_t result
);

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LEN);

	logic [2:0] exp_q;
	logic [1:0] mode_q;

	esp_pkg::item_t in_q;
	logic [31:0] mag_q;
	logic [63:0] w_q, prod_q, lo_q;
	logic [2:0]  mul_cnt_q;

	logic [63:0]   wt_q;
	logic [CW-1:0] ht_q, lt_q, pos_q;
	logic          closed_q;
	logic [30:0]   hc_q, mc_q;
	logic signed [31:0] max_q, min_q;

	logic [63:0] r_q;
	logic [30:0] quo_q;
	logic        cap_q;
	logic [4:0]  dcnt_q;

	esp_pkg::result_t out_q;
	logic             out_valid_q;

	function automatic logic [CW-1:0] inc_sat(input logic [CW-1:0] c);
		inc_sat = (c >= LEN_MAX) ? LEN_MAX : c + 1'b1;
	endfunction

	function automatic logic [63:0] add_sat64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		add_sat64 = s[64] ? {64{1'b1}} : s[63:0];
	endfunction

	function automatic logic [30:0] add_cap(input logic [30:0] a, input logic [30:0] b);
		logic [31:0] s;
		s = {1'b0, a} + {1'b0, b};
		add_cap = s[31] ? esp_pkg::Q30_CAP : s[30:0];
	endfunction

	// exponent above four acts as four
	logic [2:0]  p_eff;
	logic [31:0] mag_in;
	logic        wt_nz, len_gt_hit;
	logic [CW-1:0] miss_cnt;
	assign p_eff      = (exp_q > esp_pkg::EXP_MAX) ? esp_pkg::EXP_MAX : exp_q;
	assign mag_in     = item.stat[31] ? 32'(-item.stat) : 32'(item.stat);
	assign wt_nz      = (wt_q != 64'd0);
	assign len_gt_hit = (lt_q > ht_q);
	assign miss_cnt   = lt_q - ht_q;

	// q16 product recombine with saturation
	logic [63:0] mul_comb;
	logic [64:0] mul_sum;
	assign mul_sum  = {1'b0, prod_q[47:0], 16'b0} + {17'b0, lo_q[63:16]};
	assign mul_comb = ((prod_q[63:48] != 16'd0) || mul_sum[64]) ? {64{1'b1}} : mul_sum[63:0];

	// divider operands
	logic [63:0] num, dv;
	logic [64:0] r2;
	logic        ge_init, ge_step;
	assign num     = in_q.in_set ? w_q : 64'd1;
	assign dv      = in_q.in_set ? wt_q : {{(64-CW){1'b0}}, miss_cnt};
	assign ge_init = (num >= dv);
	assign r2      = {r_q, 1'b0};
	assign ge_step = (r2 >= {1'b0, dv});

	logic [30:0] step;
	assign step = cap_q ? esp_pkg::Q30_CAP : quo_q;

	assign sts.func     = in_q.func;
	assign sts.mul_left = (mul_cnt_q != 3'd0);
	assign sts.need_div = in_q.func && (in_q.in_set ? wt_nz : len_gt_hit);
	assign sts.div_last = (dcnt_q == 5'd1);
	assign sts.out_free = !out_valid_q || result_ready;

	// score, deviations and enrichment for the emitted beat
	logic signed [31:0] score, max_n, min_n, es;
	logic [32:0] amax, amin;
	logic        es_en;
	always_comb begin
		score = $signed({1'b0, hc_q}) - $signed({1'b0, mc_q});
		max_n = (score > max_q) ? score : max_q;
		min_n = (score < min_q) ? score : min_q;
		amax  = {1'b0, max_n};
		amin  = 33'(-$signed({min_n[31], min_n}));
		es_en = in_q.last && (ht_q != '0) && wt_nz;
		case (mode_q)
			esp_pkg::MODE_MAX: es = max_n;
			esp_pkg::MODE_MIN: es = min_n;
			default:           es = (amax >= amin) ? max_n : min_n;
		endcase
		if (!es_en) begin
			es = 32'sd0;
		end
	end

	logic [CW+16:0] pos_ext;
	assign pos_ext = {17'b0, pos_q};

	logic emit_go;
	assign emit_go = cmd.emit && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q  <= esp_pkg::EXP_RESET;
			mode_q <= esp_pkg::MODE_EXTREME;
		end else if (cfg_we) begin
			case (cfg_index)
				esp_pkg::CFG_WEIGHT_EXPONENT: exp_q  <= cfg_data;
				esp_pkg::CFG_SCORE_MODE:      mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// item, weight and divider working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q      <= item;
			mag_q     <= mag_in;
			w_q       <= (p_eff == 3'd0) ? esp_pkg::ONE_Q16 : {32'b0, mag_in};
			mul_cnt_q <= (item.in_set && (!item.func || wt_nz) && (p_eff > 3'd1))
				? p_eff - 3'd1 : 3'd0;
		end
		if (cmd.mul_lo) begin
			prod_q <= w_q[31:0] * mag_q;
		end
		if (cmd.mul_hi) begin
			lo_q   <= prod_q;
			prod_q <= w_q[63:32] * mag_q;
		end
		if (cmd.mul_acc) begin
			w_q       <= mul_comb;
			mul_cnt_q <= mul_cnt_q - 3'd1;
		end
		if (cmd.div_init) begin
			cap_q  <= ({1'b0, num} >= {dv, 1'b0});
			r_q    <= ge_init ? num - dv : num;
			quo_q  <= {30'b0, ge_init};
			dcnt_q <= esp_pkg::DIV_STEPS;
		end
		if (cmd.div_step) begin
			r_q    <= ge_step ? 64'(r2 - {1'b0, dv}) : r2[63:0];
			quo_q  <= {quo_q[29:0], ge_step};
			dcnt_q <= dcnt_q - 5'd1;
		end
		if (emit_go) begin
			out_q.position         <= pos_ext[16:0];
			out_q.running_score    <= score;
			out_q.hit              <= in_q.in_set;
			out_q.enrichment       <= es;
			out_q.enrichment_valid <= in_q.last;
		end
	end

	// totals and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wt_q        <= '0;
			ht_q        <= '0;
			lt_q        <= '0;
			pos_q       <= '0;
			closed_q    <= 1'b0;
			hc_q        <= '0;
			mc_q        <= '0;
			max_q       <= '0;
			min_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				if (!in_q.func) begin
					// a first-pass beat after closed totals starts a new list
					lt_q <= inc_sat(closed_q ? '0 : lt_q);
					if (in_q.in_set) begin
						ht_q <= inc_sat(closed_q ? '0 : ht_q);
						wt_q <= add_sat64(closed_q ? 64'd0 : wt_q, w_q);
					end else if (closed_q) begin
						ht_q <= '0;
						wt_q <= '0;
					end
					closed_q <= in_q.last;
					if (closed_q || in_q.last) begin
						pos_q <= '0;
						hc_q  <= '0;
						mc_q  <= '0;
						max_q <= '0;
						min_q <= '0;
					end
				end else begin
					closed_q <= 1'b1;
					pos_q    <= inc_sat(pos_q);
					if (in_q.in_set && wt_nz) begin
						hc_q <= add_cap(hc_q, step);
					end else if (!in_q.in_set && len_gt_hit) begin
						mc_q <= add_cap(mc_q, step);
					end
				end
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
				if (in_q.last) begin
					pos_q <= '0;
					hc_q  <= '0;
					mc_q  <= '0;
					max_q <= '0;
					min_q <= '0;
				end else begin
					max_q <= max_n;
					min_q <= min_n;
				end
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`include "enrichment_score_two_pass_macros.svh"

	`ESP_ASSERT_ALWAYS(a_hit_le_len, ht_q <= lt_q, "hit total above length total")
	`ESP_ASSERT_ALWAYS(a_dev_sign, (max_q >= 32'sd0) && (min_q <= 32'sd0), "deviation sign")
	`ESP_ASSERT_ALWAYS(a_pos_bound, pos_q <= LEN_MAX, "position count past limit")
	`ESP_ASSERT_NEXT(a_emit_valid, emit_go, out_valid_q, "emitted beat not presented")

endmodule

### design/esp_ctrl.sv
// ---------------------------------------------------------------------------
// esp_ctrl
// sequencer for one item: weight multiplies, division, update, emit
// ---------------------------------------------------------------------------
module esp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  esp_pkg::sts_t sts,
	output esp_pkg::cmd_t cmd
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_CHK      = 9'b000000010,
		S_MUL_LO   = 9'b000000100,
		S_MUL_HI   = 9'b000001000,
		S_MUL_ACC  = 9'b000010000,
		S_DIV_INIT = 9'b000100000,
		S_DIV_STEP = 9'b001000000,
		S_UPDATE   = 9'b010000000,
		S_EMIT     = 9'b100000000
	} state_t;

	state_t state_q, state_n;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_n  = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.mul_left) begin
					state_n = S_MUL_LO;
				end else if (sts.need_div) begin
					state_n = S_DIV_INIT;
				end else begin
					state_n = S_UPDATE;
				end
			end
			S_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_n    = S_MUL_HI;
			end
			S_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_n    = S_MUL_ACC;
			end
			S_MUL_ACC: begin
				cmd.mul_acc = 1'b1;
				state_n     = S_CHK;
			end
			S_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_n      = S_DIV_STEP;
			end
			S_DIV_STEP: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_n = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_n    = sts.func ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.out_free) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign item_ready = (state_q == S_IDLE);

endmodule

### design/enrichment_score_two_pass.sv
// ---------------------------------------------------------------------------
// enrichment_score_two_pass
// two-pass weighted running-sum enrichment score over a ranked list
// ---------------------------------------------------------------------------
// item channel (item_valid/item_ready/item) takes one beat per list position;
// func 0 beats build the totals and give no result, func 1 beats each give one
// result beat on result_valid/result_ready/result.
// cfg_we with cfg_index/cfg_data writes weight_exponent or score_mode; write
// only while no item is in flight.
// one item at a time: accept, a check step, then for each weight multiply
// of a hit (exponent minus one multiplies, 64x32 done as two 32x32 halves on
// one multiplier) a low, a high and an accumulate step and back to the check
// step; the shared bit-serial q30 divider, an init step and then the quotient
// steps, for a second-pass beat that takes a step; an update step and, in pass
// two, an emit step. item_ready is high again once the sequencer is back in
// idle, after the update of a first-pass beat or the emit of a second one.
// results sit in an output register; a new item is taken while it waits, and
// the sequencer holds in its emit step only if the previous result is still
// not taken.
// reset clears totals and scan state, sets exponent 1 and mode 0.
// ---------------------------------------------------------------------------
module enrichment_score_two_pass #(
	parameter int MAX_LEN = esp_pkg::DEF_MAX_LEN
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  esp_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output esp_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [2:0]       cfg_data
);

	esp_pkg::cmd_t cmd;
	esp_pkg::sts_t sts;

	esp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	esp_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
